// File: design/tts_pkg.sv
// Shared constants for the triangle tangent-space block.
// No dependencies; used by the top level and the square-root unit.
`timescale 1ns / 1ps

package tts_pkg;

  // Magnitudes are aligned so that the largest one is exactly this many bits long.
  localparam int NormBits      = 30;
  // The sum of three squared aligned magnitudes and its integer root.
  localparam int SumWidth      = 2 * NormBits + 2;
  localparam int RootWidth     = NormBits + 1;
  // Result beat layout.
  localparam int OutFieldWidth = 16;
  localparam int OutDataWidth  = 9 * OutFieldWidth;

endpackage

// File: design/triangle_tangent_space.sv
// Per-triangle tangent, binormal and normal from a vertex stream.
// Depends on tts_pkg, tts_isqrt and tts_div.
//
//   port group  dir  beat contents (lowest bits first)
//   s_axis      in   tdata: pos_x, pos_y, pos_z, tex_u, tex_v; tuser: mesh_start
//   m_axis      out  tdata: tangent, binormal, normal (x,y,z each); tuser: degenerate
//
// Flow: the first two vertices of a triangle are only stored. The third
// runs through one shared multiplier, a radix-4 root unit and a bit-serial
// divider; each vector first takes a one-bit-per-cycle alignment shift of
// up to 29 places.
// Reset clears the sequencer, the vertex count and the output register only.
// A finished result waits in the output register; vertices of the next
// triangle are still accepted, and its result waits until that register is free.
`timescale 1ns / 1ps

module triangle_tangent_space #(
  parameter int POSITION_WIDTH = 32,
  parameter int TEXCOORD_WIDTH = 16,
  parameter int OUT_FRAC_BITS  = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // pos_x, pos_y, pos_z, tex_u, tex_v, zero fill
  input  logic [((3*POSITION_WIDTH+2*TEXCOORD_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // mesh_start
  input  logic s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // tangent_x/y/z, binormal_x/y/z, normal_x/y/z
  output logic [tts_pkg::OutDataWidth-1:0] m_axis_tdata_o,
  // degenerate
  output logic m_axis_tuser_o
);
  import tts_pkg::*;

  localparam int PW   = POSITION_WIDTH;
  localparam int TW   = TEXCOORD_WIDTH;
  localparam int EW   = PW + 1;             // edge component
  localparam int DW   = TW + 1;             // texture delta
  localparam int VW   = EW + DW + 1;        // raw tangent/binormal component
  localparam int QW   = OUT_FRAC_BITS + 2;  // quotient magnitude
  localparam int SW   = QW + 1;             // signed quantized component
  localparam int NW   = 2 * SW + 1;         // raw normal component
  localparam int XW   = (VW > NW) ? VW : NW;
  localparam int MA0  = (EW > SW) ? EW : SW;
  localparam int MA   = (MA0 > NormBits + 1) ? MA0 : NormBits + 1;
  localparam int MB0  = (DW > SW) ? DW : SW;
  localparam int MB   = (MB0 > NormBits + 1) ? MB0 : NormBits + 1;
  localparam int PRW  = MA + MB;
  localparam int DivW = RootWidth + QW;

  // Product schedule lengths (issue count; the last registered product is folded in when cnt_q reaches it).
  localparam logic [3:0] MulLast   = 4'd14;
  localparam logic [3:0] SqLast    = 4'd3;
  localparam logic [3:0] CrossLast = 4'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MUL, S_NLOAD, S_SHIFT, S_SQ, S_ROOT_GO, S_ROOT_WAIT,
    S_DIV_GO, S_DIV_WAIT, S_CROSS, S_OUT
  } state_e;

  localparam logic [1:0] SetTangent  = 2'd0;
  localparam logic [1:0] SetBinormal = 2'd1;
  localparam logic [1:0] SetNormal   = 2'd2;

  // Control
  state_e                   state_q;
  logic [1:0]               phase_q, set_q, comp_q;
  logic [3:0]               cnt_q;
  logic                     deg_q;
  logic                     out_valid_q, out_user_q;
  logic [OutDataWidth-1:0]  out_data_q;

  // Datapath
  logic signed [PW-1:0]     p0_q [3], p1_q [3], p2_q [3];
  logic signed [TW-1:0]     uv0_q [2], uv1_q [2], uv2_q [2];
  logic signed [EW-1:0]     e1_q [3], e2_q [3];
  logic signed [DW-1:0]     du1_q, dv1_q, du2_q, dv2_q;
  logic signed [XW-1:0]     det_q;
  logic signed [XW-1:0]     src_q [6];
  logic [XW-1:0]            mag_q [3];
  logic                     neg_q [3];
  logic [SumWidth-1:0]      sum_q;
  logic [RootWidth-1:0]     len_q;
  logic signed [SW-1:0]     qv_q [9];
  logic signed [PRW-1:0]    p_q;

  logic                     acc;
  logic [1:0]               ph_eff;
  logic signed [PW-1:0]     in_pos [3];
  logic signed [TW-1:0]     in_uv [2];

  logic signed [MA-1:0]     mul_a;
  logic signed [MB-1:0]     mul_b;
  logic [3:0]               kacc, jm;
  logic [1:0]               cm;

  logic [XW-1:0]            ld_mag [3];
  logic                     ld_neg [3];
  logic                     ld_zero;
  logic [XW-1:0]            mag_or;
  logic                     too_big, aligned;

  logic                     root_start, root_done, div_start, div_done;
  logic [RootWidth-1:0]     root;
  logic [DivW-1:0]          div_num;
  logic [QW-1:0]            quot;
  logic signed [SW-1:0]     qsigned;
  logic [3:0]               qidx;
  logic [OutDataWidth-1:0]  out_pack;

  function automatic logic [OutFieldWidth-1:0] sat16(input logic signed [SW-1:0] v);
    logic [OutFieldWidth-1:0] r;
    if (v > $signed(32767)) begin
      r = 16'h7fff;
    end else if (v < $signed(-32768)) begin
      r = 16'h8000;
    end else begin
      r = OutFieldWidth'(v);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- input side
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign ph_eff = s_axis_tuser_i ? 2'd0 : phase_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_pos[i] = $signed(s_axis_tdata_i[i*PW +: PW]);
    end
    for (int i = 0; i < 2; i++) begin
      in_uv[i] = $signed(s_axis_tdata_i[3*PW + i*TW +: TW]);
    end
  end

  // ---------------------------------------------------------- shared multiplier
  // Issue index is cnt_q; the registered product is folded in the cycle after its issue.
  assign jm   = cnt_q - 4'd2;
  assign kacc = cnt_q - 4'd1;
  assign cm   = (jm[3:1] >= 3'd3) ? 2'(jm[3:1] - 3'd3) : jm[2:1];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL: begin
        if (cnt_q < 4'd2) begin
          mul_a = MA'(cnt_q[0] ? du2_q : du1_q);
          mul_b = MB'(cnt_q[0] ? dv1_q : dv2_q);
        end else if (cnt_q < MulLast) begin
          if (jm[3:1] < 3'd3) begin
            // tangent: dv2*e1 - dv1*e2
            mul_a = MA'(cnt_q[0] ? e2_q[cm] : e1_q[cm]);
            mul_b = MB'(cnt_q[0] ? dv1_q : dv2_q);
          end else begin
            // binormal: du1*e2 - du2*e1
            mul_a = MA'(cnt_q[0] ? e1_q[cm] : e2_q[cm]);
            mul_b = MB'(cnt_q[0] ? du2_q : du1_q);
          end
        end
      end
      S_SQ: begin
        if (cnt_q < SqLast) begin
          mul_a = MA'($signed({1'b0, mag_q[cnt_q[1:0]][NormBits-1:0]}));
          mul_b = MB'($signed({1'b0, mag_q[cnt_q[1:0]][NormBits-1:0]}));
        end
      end
      S_CROSS: begin
        case (cnt_q)
          4'd0: begin mul_a = MA'(qv_q[1]); mul_b = MB'(qv_q[5]); end
          4'd1: begin mul_a = MA'(qv_q[2]); mul_b = MB'(qv_q[4]); end
          4'd2: begin mul_a = MA'(qv_q[2]); mul_b = MB'(qv_q[3]); end
          4'd3: begin mul_a = MA'(qv_q[0]); mul_b = MB'(qv_q[5]); end
          4'd4: begin mul_a = MA'(qv_q[0]); mul_b = MB'(qv_q[4]); end
          4'd5: begin mul_a = MA'(qv_q[1]); mul_b = MB'(qv_q[3]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ------------------------------------------------------- vector load / align
  always_comb begin
    logic signed [XW-1:0] sv;
    for (int i = 0; i < 3; i++) begin
      sv = (set_q == SetBinormal) ? src_q[3+i] : src_q[i];
      // a negative determinant flips tangent and binormal
      ld_neg[i] = (sv < 0) ^ ((det_q < 0) && (set_q != SetNormal));
      ld_mag[i] = (sv < 0) ? XW'(-sv) : XW'(sv);
    end
  end

  assign ld_zero = ((ld_mag[0] | ld_mag[1] | ld_mag[2]) == '0) ||
                   ((set_q == SetTangent) && (det_q == '0));
  assign mag_or  = mag_q[0] | mag_q[1] | mag_q[2];
  assign too_big = |mag_or[XW-1:NormBits];
  assign aligned = mag_or[NormBits-1];

  // ------------------------------------------------------ root and divide units
  assign root_start = (state_q == S_ROOT_GO);
  assign div_start  = (state_q == S_DIV_GO);
  assign div_num    = ({{(DivW-NormBits){1'b0}}, mag_q[comp_q][NormBits-1:0]}
                       << OUT_FRAC_BITS) + DivW'(len_q[RootWidth-1:1]);
  assign qsigned    = neg_q[comp_q] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign qidx       = 4'(3 * set_q + comp_q);

  tts_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (sum_q),
    .done_o     (root_done),
    .root_o     (root)
  );

  tts_div #(
    .QuotWidth (QW),
    .DenWidth  (RootWidth)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (len_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      out_pack[i*OutFieldWidth +: OutFieldWidth] = sat16(qv_q[i]);
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= 2'd0;
      set_q       <= SetTangent;
      comp_q      <= 2'd0;
      cnt_q       <= 4'd0;
      deg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_user_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // drop the valid once taken, unless a new beat loads this cycle
      if (out_valid_q && m_axis_tready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (ph_eff == 2'd0) begin
              phase_q <= 2'd1;
            end else if (ph_eff == 2'd1) begin
              phase_q <= 2'd2;
            end else begin
              phase_q <= 2'd0;
              state_q <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          deg_q   <= 1'b0;
          cnt_q   <= 4'd0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (cnt_q == MulLast) begin
            set_q   <= SetTangent;
            state_q <= S_NLOAD;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_NLOAD: begin
          if (ld_zero) begin
            deg_q   <= 1'b1;
            state_q <= S_OUT;
          end else begin
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (!too_big && aligned) begin
            cnt_q   <= 4'd0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt_q == SqLast) begin
            state_q <= S_ROOT_GO;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_ROOT_GO: begin
          comp_q  <= 2'd0;
          state_q <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (root_done) begin
            state_q <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (comp_q != 2'd2) begin
              comp_q  <= comp_q + 2'd1;
              state_q <= S_DIV_GO;
            end else if (set_q == SetTangent) begin
              set_q   <= SetBinormal;
              state_q <= S_NLOAD;
            end else if (set_q == SetBinormal) begin
              cnt_q   <= 4'd0;
              state_q <= S_CROSS;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_CROSS: begin
          if (cnt_q == CrossLast) begin
            set_q   <= SetNormal;
            state_q <= S_NLOAD;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_user_q  <= deg_q;
            out_data_q  <= deg_q ? '0 : out_pack;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // ----------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;

    if (acc) begin
      if (ph_eff == 2'd0) begin
        p0_q  <= in_pos;
        uv0_q <= in_uv;
      end else if (ph_eff == 2'd1) begin
        p1_q  <= in_pos;
        uv1_q <= in_uv;
      end else begin
        p2_q  <= in_pos;
        uv2_q <= in_uv;
      end
    end

    case (state_q)
      S_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= EW'(p1_q[i]) - EW'(p0_q[i]);
          e2_q[i] <= EW'(p2_q[i]) - EW'(p0_q[i]);
        end
        du1_q <= DW'(uv1_q[0]) - DW'(uv0_q[0]);
        dv1_q <= DW'(uv1_q[1]) - DW'(uv0_q[1]);
        du2_q <= DW'(uv2_q[0]) - DW'(uv0_q[0]);
        dv2_q <= DW'(uv2_q[1]) - DW'(uv0_q[1]);
      end
      S_MUL: begin
        if (cnt_q != 4'd0) begin
          if (kacc < 4'd2) begin
            det_q <= kacc[0] ? det_q - XW'(p_q) : XW'(p_q);
          end else begin
            src_q[3'((kacc - 4'd2) >> 1)] <= kacc[0] ?
                src_q[3'((kacc - 4'd2) >> 1)] - XW'(p_q) : XW'(p_q);
          end
        end
      end
      S_NLOAD: begin
        mag_q <= ld_mag;
        neg_q <= ld_neg;
      end
      S_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (too_big) begin
            mag_q[i] <= mag_q[i] >> 1;
          end else if (!aligned) begin
            mag_q[i] <= mag_q[i] << 1;
          end
        end
      end
      S_SQ: begin
        if (cnt_q != 4'd0) begin
          sum_q <= (kacc == 4'd0) ? SumWidth'(p_q) : sum_q + SumWidth'(p_q);
        end
      end
      S_ROOT_WAIT: begin
        if (root_done) begin
          len_q <= root;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          qv_q[qidx] <= qsigned;
        end
      end
      S_CROSS: begin
        if (cnt_q != 4'd0) begin
          src_q[3'(kacc >> 1)] <= kacc[0] ?
              src_q[3'(kacc >> 1)] - XW'(p_q) : XW'(p_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // --------------------------------------------------------------- assertions
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("degenerate beat carries nonzero vectors");

  a_phase_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIFF |-> phase_q == 2'd0 && $past(acc))
    else $error("triangle started without resetting the vertex count");

  a_root_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> state_q == S_ROOT_WAIT)
    else $error("root result outside its wait state");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV_WAIT && !root_done)
    else $error("divider result outside its wait state");

endmodule

// File: design/tts_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on tts_pkg for SumWidth and RootWidth.
`timescale 1ns / 1ps

module tts_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tts_pkg::SumWidth-1:0]   radicand_i,
  output logic                           done_o,
  output logic [tts_pkg::RootWidth-1:0]  root_o
);
  import tts_pkg::*;

  localparam int CntW = $clog2(RootWidth);

  logic                 busy_q, done_q;
  logic [CntW-1:0]      cnt_q;
  logic [SumWidth-1:0]  s_q;
  logic [RootWidth+1:0] rem_q;
  logic [RootWidth-1:0] root_q;

  logic [RootWidth+3:0] rem_n, trial;
  logic                 fits;

  assign rem_n = {rem_q, s_q[SumWidth-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign fits  = rem_n >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(RootWidth - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      s_q <= s_q << 2;
      if (fits) begin
        rem_q  <= (RootWidth + 2)'(rem_n - trial);
        root_q <= {root_q[RootWidth-2:0], 1'b1};
      end else begin
        rem_q  <= (RootWidth + 2)'(rem_n);
        root_q <= {root_q[RootWidth-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: design/tts_div.sv
// Restoring divider, one quotient bit per cycle, quotient known to fit QuotWidth bits.
// Stand-alone; used by the top level for the rounded unit-vector components.
`timescale 1ns / 1ps

module tts_div #(
  parameter int QuotWidth = 16,
  parameter int DenWidth  = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DenWidth+QuotWidth-1:0] num_i,
  input  logic [DenWidth-1:0]           den_i,
  output logic                          done_o,
  output logic [QuotWidth-1:0]          quot_o
);

  localparam int NumW = DenWidth + QuotWidth;
  localparam int CntW = $clog2(QuotWidth);

  logic                 busy_q, done_q;
  logic [CntW-1:0]      cnt_q;
  logic [NumW-1:0]      r_q, d_q;
  logic [QuotWidth-1:0] q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QuotWidth - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= num_i;
      d_q <= NumW'(den_i) << (QuotWidth - 1);
      q_q <= '0;
    end else if (busy_q) begin
      d_q <= d_q >> 1;
      if (r_q >= d_q) begin
        r_q <= r_q - d_q;
        q_q <= {q_q[QuotWidth-2:0], 1'b1};
      end else begin
        q_q <= {q_q[QuotWidth-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

// File: bench/triangle_tangent_space_test.sv
// Self-checking bench for triangle_tangent_space: streams vertices, predicts
// each triangle's tangent frame in a scoreboard class and checks every beat.
// Depends on tts_pkg and the design files.
`timescale 1ns / 1ps

module triangle_tangent_space_test;

  localparam int PosW    = 32;
  localparam int TexW    = 16;
  localparam int FracW   = 14;
  localparam int InWidth = ((3 * PosW + 2 * TexW + 7) / 8) * 8;

  typedef struct {
    logic [tts_pkg::OutDataWidth-1:0] frame;
    logic                             degenerate;
  } frame_t;

  // Holds the vertex grouping state and the queue of predicted frames.
  class frame_scoreboard;
    logic [1:0]  phase;
    longint      pos_hold [6];
    longint      tex_hold [4];
    frame_t      pending [$];
    int          errors;
    int          frames_seen;
    int          degenerate_seen;

    function new();
      phase = 0;
      errors = 0;
      frames_seen = 0;
      degenerate_seen = 0;
    endfunction

    static function int bit_length(longint unsigned v);
      int n;
      n = 0;
      while (v != 0) begin
        n++;
        v >>= 1;
      end
      return n;
    endfunction

    static function longint unsigned int_root(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Scale to unit length with FracW fraction bits; 0 on a zero vector.
    static function bit unit_vec(input longint v [3], output longint q [3]);
      longint unsigned m [3];
      longint unsigned sum, len, u;
      int lmax, l;
      lmax = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = (v[i] < 0) ? -v[i] : v[i];
        l = bit_length(m[i]);
        if (l > lmax) lmax = l;
      end
      if (lmax == 0) return 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = (lmax <= 30) ? (m[i] << (30 - lmax)) : (m[i] >> (lmax - 30));
        sum += m[i] * m[i];
      end
      len = int_root(sum);
      for (int i = 0; i < 3; i++) begin
        u = ((m[i] << FracW) + (len >> 1)) / len;
        q[i] = (v[i] < 0) ? -longint'(u) : longint'(u);
      end
      return 1;
    endfunction

    static function logic [15:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    // Note one accepted vertex; the third of a triangle queues a frame.
    function void note_vertex(logic [InWidth-1:0] d, logic start);
      longint p [3], e1 [3], e2 [3], tv [3], bv [3], nv [3], t [3], b [3], n [3];
      longint u, v, du1, dv1, du2, dv2, det;
      frame_t f;
      bit ok;
      for (int i = 0; i < 3; i++) p[i] = longint'($signed(d[i*PosW +: PosW]));
      u = longint'($signed(d[3*PosW +: TexW]));
      v = longint'($signed(d[3*PosW+TexW +: TexW]));
      if (start) phase = 0;
      if (phase != 2) begin
        for (int i = 0; i < 3; i++) pos_hold[phase*3 + i] = p[i];
        tex_hold[phase*2]     = u;
        tex_hold[phase*2 + 1] = v;
        phase++;
        return;
      end
      phase = 0;
      for (int i = 0; i < 3; i++) begin
        e1[i] = pos_hold[3+i] - pos_hold[i];
        e2[i] = p[i] - pos_hold[i];
      end
      du1 = tex_hold[2] - tex_hold[0];
      dv1 = tex_hold[3] - tex_hold[1];
      du2 = u - tex_hold[0];
      dv2 = v - tex_hold[1];
      det = du1 * dv2 - du2 * dv1;
      for (int i = 0; i < 3; i++) begin
        tv[i] = dv2 * e1[i] - dv1 * e2[i];
        bv[i] = du1 * e2[i] - du2 * e1[i];
        if (det < 0) begin
          tv[i] = -tv[i];
          bv[i] = -bv[i];
        end
      end
      ok = (det != 0) && unit_vec(tv, t) && unit_vec(bv, b);
      if (ok) begin
        nv[0] = t[1] * b[2] - t[2] * b[1];
        nv[1] = t[2] * b[0] - t[0] * b[2];
        nv[2] = t[0] * b[1] - t[1] * b[0];
        ok = unit_vec(nv, n);
      end
      f.frame = '0;
      f.degenerate = !ok;
      if (ok) begin
        for (int i = 0; i < 3; i++) begin
          f.frame[i*16 +: 16]       = clamp16(t[i]);
          f.frame[(3+i)*16 +: 16]   = clamp16(b[i]);
          f.frame[(6+i)*16 +: 16]   = clamp16(n[i]);
        end
      end
      pending.push_back(f);
    endfunction

    // Compare one result beat against the oldest predicted frame.
    function void check_frame(logic [tts_pkg::OutDataWidth-1:0] d, logic deg);
      string names [9] = '{"tangent_x", "tangent_y", "tangent_z",
                           "binormal_x", "binormal_y", "binormal_z",
                           "normal_x", "normal_y", "normal_z"};
      frame_t f;
      if (pending.size() == 0) begin
        $error("result beat with no triangle outstanding");
        errors++;
        return;
      end
      f = pending.pop_front();
      frames_seen++;
      if (f.degenerate) degenerate_seen++;
      for (int i = 0; i < 9; i++) begin
        if (d[i*16 +: 16] !== f.frame[i*16 +: 16]) begin
          $error("%s: expected %0d, got %0d", names[i],
                 $signed(f.frame[i*16 +: 16]), $signed(d[i*16 +: 16]));
          errors++;
        end
      end
      if (deg !== f.degenerate) begin
        $error("degenerate: expected %0b, got %0b", f.degenerate, deg);
        errors++;
      end
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [InWidth-1:0]               s_axis_tdata_i = '0;
  logic                             s_axis_tuser_i = 1'b0;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [tts_pkg::OutDataWidth-1:0] m_axis_tdata_o;
  logic                             m_axis_tuser_o;

  frame_scoreboard tracker = new();
  int              tx_idle_pct = 0;
  int              rx_idle_pct = 0;
  int              vertices_sent = 0;

  triangle_tangent_space uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  always #1 clk_i = ~clk_i;

  // Receiver: stall at random at the falling edge, check beats at the rising edge.
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      tracker.check_frame(m_axis_tdata_o, m_axis_tuser_o);
  end

  // Drive one vertex beat, with random gaps ahead of it.
  task automatic send_vertex(longint px, longint py, longint pz, int u, int v, bit start);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {v[15:0], u[15:0], pz[31:0], py[31:0], px[31:0]};
    s_axis_tuser_i  <= start;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_vertex({v[15:0], u[15:0], pz[31:0], py[31:0], px[31:0]}, start);
    vertices_sent++;
  endtask

  function automatic longint rand_pos(bit wide);
    if (wide) return longint'($signed($urandom()));
    return longint'($urandom_range(8192)) - 4096;
  endfunction

  function automatic int rand_tex(bit wide);
    if (wide) return int'($signed(16'($urandom())));
    return int'($urandom_range(2048)) - 1024;
  endfunction

  // Random triangles, mostly well formed; some break the grouping with mesh_start.
  task automatic random_vertices(int count);
    bit wide;
    for (int i = 0; i < count; i++) begin
      wide = ($urandom_range(3) == 0);
      send_vertex(rand_pos(wide), rand_pos(wide), rand_pos(wide),
                  rand_tex(wide), rand_tex(wide), ($urandom_range(19) == 0));
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Extremes of every field, plain unit triangle.
    send_vertex(0, 0, 0, 0, 0, 1);
    send_vertex(65536, 0, 0, 4096, 0, 0);
    send_vertex(0, 65536, 0, 0, 4096, 0);
    send_vertex(-2147483648, -2147483648, -2147483648, -32768, -32768, 0);
    send_vertex(2147483647, 2147483647, 2147483647, 32767, 32767, 0);
    send_vertex(2147483647, -2147483648, 0, -32768, 32767, 0);
    // Zero determinant: identical texture coordinates.
    send_vertex(0, 0, 0, 100, 100, 0);
    send_vertex(1000, 0, 0, 100, 100, 0);
    send_vertex(0, 1000, 0, 100, 100, 0);
    // Zero tangent and binormal: coincident positions.
    send_vertex(5, 5, 5, 0, 0, 0);
    send_vertex(5, 5, 5, 4096, 0, 0);
    send_vertex(5, 5, 5, 0, 4096, 0);
    // Collinear positions give parallel tangent and binormal: zero normal.
    send_vertex(0, 0, 0, 0, 0, 0);
    send_vertex(100, 200, 300, 4096, 0, 0);
    send_vertex(200, 400, 600, 0, 4096, 0);
    // mesh_start in the middle of a triangle drops the held vertices.
    send_vertex(9999, 9999, 9999, 7, 7, 0);
    send_vertex(0, 0, 0, 0, 0, 1);
    send_vertex(0, 0, 65536, 0, 4096, 0);
    send_vertex(-65536, 0, 0, -4096, 0, 0);
    send_vertex(1, 2, 3, 4, 5, 0);
    send_vertex(3, 2, 1, 5, 4, 1);
    send_vertex(-3, 7, 1, -5, 9, 0);
    send_vertex(8, -1, 4, 2, -6, 0);

    tx_idle_pct = 8;  rx_idle_pct = 52; random_vertices(280);
    tx_idle_pct = 52; rx_idle_pct = 8;  random_vertices(280);
    tx_idle_pct = 0;  rx_idle_pct = 0;  random_vertices(290);

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    wait_cycles = 0;
    while (tracker.pending.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (1000) @(posedge clk_i);

    if (tracker.pending.size() != 0) begin
      $error("%0d predicted frames never arrived", tracker.pending.size());
      tracker.errors++;
    end
    $display("Streamed %0d vertices; checked %0d frames, %0d of them degenerate.",
             vertices_sent, tracker.frames_seen, tracker.degenerate_seen);
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1500000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
